FILE: hdl/slx_pkg.sv
package slx_pkg;

  localparam int QDEPTH = 4;
  localparam int QAW = $clog2(QDEPTH);
  localparam int MAXEV = 3;

  localparam logic [1:0] KIND_SYMBOL = 2'd0;
  localparam logic [1:0] KIND_MACRO  = 2'd1;
  localparam logic [1:0] KIND_STRING = 2'd2;
  localparam logic [1:0] KIND_INT    = 2'd3;

  localparam logic EV_APPEND = 1'b0;
  localparam logic EV_END    = 1'b1;

  localparam logic CMD_CHAR = 1'b0;
  localparam logic CMD_EOI  = 1'b1;

  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_STRING = 3'd1,
    MODE_STRESC = 3'd2,
    MODE_INT    = 3'd3,
    MODE_SYMBOL = 3'd4,
    MODE_SYMESC = 3'd5,
    MODE_DOT    = 3'd6
  } lex_mode_t;

  typedef struct packed {
    logic       command;
    logic [7:0] char_in;
  } in_item_t;

  typedef struct packed {
    logic       event_kind;
    logic [7:0] char_out;
    logic [1:0] token_kind;
    logic       last;
  } out_item_t;

  typedef struct packed {
    lex_mode_t  mode;
    logic [1:0] pkind;
    logic       tok_open;
  } lex_state_t;

  localparam lex_state_t LEX_RESET = '{mode: MODE_NORMAL, pkind: KIND_SYMBOL, tok_open: 1'b0};

  typedef struct packed {
    logic       kind;
    logic [7:0] ch;
    logic [1:0] tk;
  } ev_t;

  typedef struct packed {
    logic [1:0]         cnt;
    ev_t [MAXEV-1:0]    evs;
  } bundle_t;

  typedef struct packed {
    logic    valid;
    bundle_t b;
  } q_push_t;

  typedef struct packed {
    lex_state_t      s;
    logic [1:0]      n;
    ev_t [MAXEV-1:0] evs;
  } acc_t;

  function automatic logic is_bracket(logic [7:0] c);
    return c == CH_LPAREN || c == CH_RPAREN || c == CH_LBRACK || c == CH_RBRACK;
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return c == CH_SPACE || c == CH_NL || c == CH_TAB;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= CH_ZERO && c <= CH_NINE;
  endfunction

  function automatic acc_t put_ev(acc_t a, logic k, logic [7:0] c, logic [1:0] t);
    acc_t r;
    r = a;
    if (r.n != 2'(MAXEV)) begin
      r.evs[r.n] = '{kind: k, ch: c, tk: t};
      r.n = r.n + 2'd1;
    end
    return r;
  endfunction

  function automatic acc_t add_char(acc_t a, logic [7:0] c);
    acc_t r;
    r = put_ev(a, EV_APPEND, c, KIND_SYMBOL);
    r.s.tok_open = 1'b1;
    return r;
  endfunction

  function automatic acc_t end_token(acc_t a);
    acc_t r;
    r = put_ev(a, EV_END, 8'h00, a.s.pkind);
    r.s.pkind = KIND_SYMBOL;
    r.s.tok_open = 1'b0;
    return r;
  endfunction

  // one character through the mode machine, with up to four passes
  function automatic acc_t lex_char(lex_state_t st, logic [7:0] c);
    acc_t a;
    logic done;
    a = '{s: st, n: 2'd0, evs: '0};
    done = 1'b0;
    for (int p = 0; p < 4; p++) begin
      if (!done) begin
        case (a.s.mode)
          MODE_STRING: begin
            if (c == CH_BSLASH) a.s.mode = MODE_STRESC;
            else if (c == CH_QUOTE) a.s.mode = MODE_NORMAL;
            else a = add_char(a, c);
            done = 1'b1;
          end
          MODE_STRESC: begin
            a = add_char(a, c);
            a.s.mode = MODE_STRING;
            done = 1'b1;
          end
          MODE_INT: begin
            if (is_digit(c)) begin
              a = add_char(a, c);
              done = 1'b1;
            end else begin
              a.s.mode = MODE_NORMAL;
              a = end_token(a);
            end
          end
          MODE_SYMBOL: begin
            if (is_bracket(c) || is_space(c)) begin
              a.s.mode = MODE_NORMAL;
              a = end_token(a);
            end else begin
              if (c == CH_BSLASH) a.s.mode = MODE_SYMESC;
              else a = add_char(a, c);
              done = 1'b1;
            end
          end
          MODE_SYMESC: begin
            a = add_char(a, c);
            a.s.mode = MODE_SYMBOL;
            done = 1'b1;
          end
          MODE_DOT: begin
            a.s.mode = MODE_NORMAL;
            if (is_bracket(c) || is_space(c)) a = end_token(a);
            else a.s.pkind = KIND_SYMBOL;
          end
          default: begin
            a.s.mode = MODE_NORMAL;
            if (is_bracket(c)) begin
              if (a.s.tok_open) begin
                a = end_token(a);
              end else begin
                a.s.pkind = KIND_MACRO;
                a = add_char(a, c);
                a = end_token(a);
                done = 1'b1;
              end
            end else if (c == CH_DOT) begin
              a.s.mode = MODE_DOT;
              a.s.pkind = KIND_MACRO;
              a = add_char(a, c);
              done = 1'b1;
            end else if (is_space(c)) begin
              if (a.s.tok_open) a = end_token(a);
              done = 1'b1;
            end else if (c == CH_QUOTE) begin
              if (a.s.tok_open) begin
                a = end_token(a);
              end else begin
                a.s.mode = MODE_STRING;
                a.s.pkind = KIND_STRING;
                done = 1'b1;
              end
            end else if (is_digit(c)) begin
              if (a.s.tok_open) begin
                a = end_token(a);
              end else begin
                a.s.mode = MODE_INT;
                a.s.pkind = KIND_INT;
                a = add_char(a, c);
                done = 1'b1;
              end
            end else begin
              a.s.mode = MODE_SYMBOL;
              a = add_char(a, c);
              done = 1'b1;
            end
          end
        endcase
      end
    end
    return a;
  endfunction

  function automatic acc_t lex_step(lex_state_t st, in_item_t it);
    acc_t a;
    if (it.command == CMD_EOI) begin
      a = '{s: st, n: 2'd0, evs: '0};
      if (st.tok_open) a = end_token(a);
      a.s = LEX_RESET;
    end else begin
      a = lex_char(st, it.char_in);
    end
    return a;
  endfunction

endpackage

FILE: hdl/slx_front.sv
module slx_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  slx_pkg::in_item_t   in_data,
  input  logic                q_ready,
  output slx_pkg::q_push_t    q_push,
  output slx_pkg::lex_state_t st
);
  import slx_pkg::*;

  lex_state_t st_r, st_nxt;
  acc_t       res;
  logic       accept;

  assign in_ready = q_ready;
  assign accept   = in_valid && q_ready;
  assign st       = st_r;

  always_comb begin
    res = lex_step(st_r, in_data);
    st_nxt = st_r;
    if (accept) st_nxt = res.s;
    q_push.valid = accept && (res.n != 2'd0);
    q_push.b.cnt = res.n;
    q_push.b.evs = res.evs;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= LEX_RESET;
    else st_r <= st_nxt;
  end

endmodule

FILE: hdl/slx_back.sv
module slx_back (
  input  logic               clk,
  input  logic               rst_n,
  input  slx_pkg::q_push_t   q_push,
  output logic               q_ready,
  output logic               out_valid,
  input  logic               out_ready,
  output slx_pkg::out_item_t out_data
);
  import slx_pkg::*;

  bundle_t        mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]   count_r, count_nxt;
  logic [1:0]     idx_r, idx_nxt;
  bundle_t        head;
  ev_t            ev;
  logic           is_last;
  logic           take;
  logic           pop;

  assign q_ready   = count_r != (QAW+1)'(QDEPTH);
  assign out_valid = count_r != '0;
  assign head      = mem_r[rd_ptr_r];
  assign ev        = head.evs[idx_r];
  assign is_last   = idx_r == (head.cnt - 2'd1);
  assign take      = out_valid && out_ready;
  assign pop       = take && is_last;

  assign out_data.event_kind = ev.kind;
  assign out_data.char_out   = ev.ch;
  assign out_data.token_kind = ev.tk;
  assign out_data.last       = is_last;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    if (q_push.valid) wr_ptr_nxt = wr_ptr_r + 1'b1;
    if (pop) rd_ptr_nxt = rd_ptr_r + 1'b1;
    if (take) idx_nxt = is_last ? 2'd0 : idx_r + 2'd1;
    if (q_push.valid && !pop) count_nxt = count_r + 1'b1;
    else if (!q_push.valid && pop) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
      idx_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
      idx_r    <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_push.valid) mem_r[wr_ptr_r] <= q_push.b;
  end

endmodule

FILE: hdl/sexpr_token_lexer_core.sv
// the events of a taken request are registered into the event queue and offered from its head
// throughput: one request per cycle while the four-entry event queue has room
// each request yields zero to three events, sent one per cycle from the queue head while out_ready is high
// reset: lexer back to normal mode, symbol kind, no open token; event queue empty
module sexpr_token_lexer_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  slx_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output slx_pkg::out_item_t out_data
);
  import slx_pkg::*;

  q_push_t    q_push;
  logic       q_ready;
  lex_state_t st;

  slx_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_ready  (q_ready),
    .q_push   (q_push),
    .st       (st)
  );

  slx_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_push    (q_push),
    .q_ready   (q_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // empty bundles never enter the queue
  a_push_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_push.valid |-> q_push.b.cnt != 2'd0)
    else $error("empty event bundle pushed");

  // end of input returns the lexer to its reset state
  a_eoi_reset: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_data.command == CMD_EOI |=> st == LEX_RESET)
    else $error("lexer state not cleared after end of input");

  // appends carry no token kind, token ends carry no character
  a_event_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.event_kind == EV_APPEND && out_data.token_kind == KIND_SYMBOL)
      || (out_data.event_kind == EV_END && out_data.char_out == 8'h00))
    else $error("event fields inconsistent");

  // nothing is pushed while the queue is full
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push.valid |-> q_ready)
    else $error("push into full event queue");

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import slx_pkg::*;

  class lex_scoreboard;
    lex_mode_t  mode;
    logic [1:0] pkind;
    logic       tok_open;
    out_item_t  expected_q[$];
    out_item_t  step_evs[$];
    int         errors;

    function new();
      reset_state();
      errors = 0;
    endfunction

    function void reset_state();
      mode = MODE_NORMAL;
      pkind = KIND_SYMBOL;
      tok_open = 1'b0;
    endfunction

    function bit bracket_char(logic [7:0] c);
      return c == CH_LPAREN || c == CH_RPAREN || c == CH_LBRACK || c == CH_RBRACK;
    endfunction

    function bit blank_char(logic [7:0] c);
      return c == CH_SPACE || c == CH_NL || c == CH_TAB;
    endfunction

    function bit digit_char(logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    // events past the third are dropped
    function void push_event(logic kind, logic [7:0] ch, logic [1:0] tk);
      out_item_t e;
      if (step_evs.size() < MAXEV) begin
        e = '{event_kind: kind, char_out: ch, token_kind: tk, last: 1'b0};
        step_evs.insert(step_evs.size(), e);
      end
    endfunction

    function void append(logic [7:0] c);
      push_event(EV_APPEND, c, KIND_SYMBOL);
      tok_open = 1'b1;
    endfunction

    function void close_token();
      push_event(EV_END, 8'h00, pkind);
      pkind = KIND_SYMBOL;
      tok_open = 1'b0;
    endfunction

    // a terminator of a symbol or number, and any character after a dot, goes round again in normal mode
    function void scan_char(logic [7:0] c);
      bit again;
      int pass;
      again = 1'b1;
      for (pass = 0; pass < 4 && again; pass++) begin
        again = 1'b0;
        case (mode)
          MODE_STRING: begin
            if (c == CH_BSLASH) mode = MODE_STRESC;
            else if (c == CH_QUOTE) mode = MODE_NORMAL;
            else append(c);
          end
          MODE_STRESC: begin
            append(c);
            mode = MODE_STRING;
          end
          MODE_INT: begin
            if (digit_char(c)) begin
              append(c);
            end else begin
              mode = MODE_NORMAL;
              close_token();
              again = 1'b1;
            end
          end
          MODE_SYMBOL: begin
            if (bracket_char(c) || blank_char(c)) begin
              mode = MODE_NORMAL;
              close_token();
              again = 1'b1;
            end else if (c == CH_BSLASH) begin
              mode = MODE_SYMESC;
            end else begin
              append(c);
            end
          end
          MODE_SYMESC: begin
            append(c);
            mode = MODE_SYMBOL;
          end
          MODE_DOT: begin
            mode = MODE_NORMAL;
            if (bracket_char(c) || blank_char(c)) close_token();
            else pkind = KIND_SYMBOL;
            again = 1'b1;
          end
          default: begin
            mode = MODE_NORMAL;
            if (bracket_char(c)) begin
              if (tok_open) begin
                close_token();
                again = 1'b1;
              end else begin
                pkind = KIND_MACRO;
                append(c);
                close_token();
              end
            end else if (c == CH_DOT) begin
              mode = MODE_DOT;
              pkind = KIND_MACRO;
              append(c);
            end else if (blank_char(c)) begin
              if (tok_open) close_token();
            end else if (c == CH_QUOTE) begin
              if (tok_open) begin
                close_token();
                again = 1'b1;
              end else begin
                mode = MODE_STRING;
                pkind = KIND_STRING;
              end
            end else if (digit_char(c)) begin
              if (tok_open) begin
                close_token();
                again = 1'b1;
              end else begin
                mode = MODE_INT;
                pkind = KIND_INT;
                append(c);
              end
            end else begin
              mode = MODE_SYMBOL;
              append(c);
            end
          end
        endcase
      end
    endfunction

    function void note_request(in_item_t it);
      step_evs.delete();
      if (it.command == CMD_EOI) begin
        if (tok_open) close_token();
        reset_state();
      end else begin
        scan_char(it.char_in);
      end
      if (step_evs.size() > 0) step_evs[step_evs.size() - 1].last = 1'b1;
      foreach (step_evs[i]) expected_q.insert(expected_q.size(), step_evs[i]);
    endfunction

    function void report_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: event with none pending, expected none actual %p", $time, got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      report_field("event_kind", want.event_kind, got.event_kind);
      report_field("char_out", want.char_out, got.char_out);
      report_field("token_kind", want.token_kind, got.token_kind);
      report_field("last", want.last, got.last);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  lex_scoreboard sb = new();
  int sent = 0;
  int burst_left = 0;
  int rx_cyc = 0;
  logic [1:0] rx_mode = 2'd0;

  sexpr_token_lexer_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always #5 clk = ~clk;

  function automatic in_item_t mk_char(logic [7:0] c);
    return '{command: CMD_CHAR, char_in: c};
  endfunction

  function automatic logic [7:0] sym_char();
    if ($urandom_range(0, 4) != 0) return 8'($urandom_range(8'h61, 8'h7A));
    return 8'($urandom_range(8'h80, 8'hFF));
  endfunction

  function automatic logic [7:0] pick_bracket();
    case ($urandom_range(0, 3))
      0: return CH_LPAREN;
      1: return CH_RPAREN;
      2: return CH_LBRACK;
      default: return CH_RBRACK;
    endcase
  endfunction

  // sender works in bursts; valid stays up between back-to-back requests
  task automatic send_request(input in_item_t it);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(it);
    sent++;
  endtask

  task automatic send_sep();
    case ($urandom_range(0, 5))
      0: send_request(mk_char(CH_SPACE));
      1: send_request(mk_char(CH_NL));
      2: send_request(mk_char(CH_TAB));
      3: send_request(mk_char(pick_bracket()));
      4: ;
      default: send_request('{command: CMD_EOI, char_in: 8'($urandom_range(0, 255))});
    endcase
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // receiver stall pattern is redrawn periodically from four patterns
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
    rx_cyc <= rx_cyc + 1;
    if (rx_cyc % 50 == 0) rx_mode <= 2'($urandom_range(0, 3));
    case (rx_mode)
      2'd0: out_ready <= 1'b1;
      2'd1: out_ready <= 1'($urandom_range(0, 1));
      2'd2: out_ready <= (rx_cyc % 4 == 0);
      default: out_ready <= (rx_cyc % 16 >= 12);
    endcase
  end

  initial begin
    in_item_t directed[$];
    int total;
    int n;
    bit drained;
    drained = 1'b0;

    directed = '{
      mk_char(CH_LPAREN), mk_char("a"), mk_char(CH_BSLASH), mk_char(CH_SPACE),
      mk_char(CH_RPAREN), mk_char(CH_ZERO), mk_char("x"), mk_char(CH_TAB),
      // empty string, then a symbol typed as string
      mk_char(CH_QUOTE), mk_char(CH_QUOTE), mk_char("b"), mk_char(CH_NL),
      // escaped quote, then text after the closing quote
      mk_char(CH_QUOTE), mk_char(CH_BSLASH), mk_char(CH_QUOTE), mk_char(CH_QUOTE),
      mk_char("c"), mk_char(CH_DOT), mk_char(CH_RBRACK),
      mk_char(CH_DOT), mk_char("q"), mk_char(8'h00), mk_char(8'hFF),
      mk_char(CH_BSLASH), '{command: CMD_EOI, char_in: 8'hFF}
    };

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) send_request(directed[i]);
    drain();

    total = sent + 200;
    while (sent < total) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          n = $urandom_range(1, 5);
          repeat (n) begin
            if ($urandom_range(0, 6) == 0) begin
              send_request(mk_char(CH_BSLASH));
              send_request(mk_char(8'($urandom_range(0, 255))));
            end else begin
              send_request(mk_char(sym_char()));
            end
          end
          send_sep();
        end
        2, 3: begin
          n = $urandom_range(1, 4);
          repeat (n) send_request(mk_char(8'($urandom_range(CH_ZERO, CH_NINE))));
          send_sep();
        end
        4, 5: begin
          send_request(mk_char(CH_QUOTE));
          n = $urandom_range(0, 5);
          repeat (n) begin
            if ($urandom_range(0, 5) == 0) begin
              send_request(mk_char(CH_BSLASH));
              send_request(mk_char(8'($urandom_range(0, 255))));
            end else begin
              send_request(mk_char(8'($urandom_range(8'h20, 8'h7E))));
            end
          end
          if ($urandom_range(0, 7) != 0) send_request(mk_char(CH_QUOTE));
          if ($urandom_range(0, 1) == 0) send_sep();
        end
        6: send_request(mk_char(pick_bracket()));
        7: begin
          send_request(mk_char(CH_DOT));
          if ($urandom_range(0, 1) == 0) send_request(mk_char(sym_char()));
          else send_sep();
        end
        8: begin
          n = $urandom_range(1, 4);
          repeat (n) send_request(mk_char(8'($urandom_range(0, 255))));
        end
        default: send_request('{command: CMD_EOI, char_in: 8'($urandom_range(0, 255))});
      endcase
      if (!drained && sent > total - 100) begin
        drain();
        drained = 1'b1;
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end

  initial begin
    #2000000;
    $display("tb_top: errors");
    $finish;
  end

endmodule

FILE: sexpr_token_lexer_core.f
hdl/slx_pkg.sv
hdl/slx_front.sv
hdl/slx_back.sv
hdl/sexpr_token_lexer_core.sv
test/tb_top.sv
